// ===== design/hfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_pkg
// shared constants, types and the hex digit decode for the hex frame receiver
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int LINE_CHARS = 64;
  localparam int CIDX_W     = $clog2(LINE_CHARS);

  localparam logic [7:0] SUM_TARGET    = 8'h55;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_NUL      = 8'h00;
  localparam logic [6:0] MAX_BYTES_RST = 7'd32;
  localparam logic [6:0] COUNT_MAX     = 7'd127;

  typedef struct packed {
    logic              in_frame;
    logic [CIDX_W-1:0] char_index;
    logic              low_nibble_next;
    logic [3:0]        high_nibble;
    logic [7:0]        running_sum;
    logic [7:0]        held_byte;
    logic              held_valid;
    logic [6:0]        decoded_count;
    logic              decode_stopped;
    logic              frame_failed;
  } frame_state_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       frame_ok;
    logic [4:0] frame_length;
  } frame_result_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end
    return d[3:0];
  endfunction

endpackage

// ===== design/hfr_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfr_step
// next frame state and result for one received character
// ----------------------------------------------------------------------------
module hfr_step (
  input  hfr_pkg::frame_state_t  cur,
  input  logic [7:0]             rx_char,
  input  logic [6:0]             max_bytes,
  output hfr_pkg::frame_state_t  nxt,
  output hfr_pkg::frame_result_t res,
  output logic                   has_result
);
  import hfr_pkg::*;

  logic       is_colon;
  logic       is_newline;
  logic       is_nul;
  logic       active;
  logic       taken;
  logic       do_finish;
  logic [3:0] low_val;
  logic [7:0] new_byte;
  logic       ok;

  assign is_colon   = (rx_char == CHAR_COLON);
  assign is_newline = (rx_char == CHAR_NEWLINE);
  assign is_nul     = (rx_char == CHAR_NUL);
  assign active     = !cur.decode_stopped && !cur.frame_failed;
  assign taken      = cur.in_frame && (cur.char_index < CIDX_W'(LINE_CHARS - 1));

  always_comb begin
    nxt       = cur;
    res       = '0;
    do_finish = 1'b0;
    low_val   = 4'd0;
    new_byte  = 8'h00;
    ok        = 1'b0;

    if (is_colon) begin
      nxt                 = '0;
      nxt.in_frame        = 1'b1;
      nxt.char_index      = CIDX_W'(1);
      nxt.low_nibble_next = 1'b1;
    end else if (taken) begin
      nxt.char_index = cur.char_index + CIDX_W'(1);
      if (is_newline || is_nul) begin
        do_finish = active && cur.low_nibble_next;
        if (is_nul) begin
          nxt.decode_stopped = 1'b1;
        end
      end else if (active) begin
        if (cur.low_nibble_next) begin
          do_finish = 1'b1;
          low_val   = hex_value(rx_char);
        end else begin
          nxt.high_nibble     = hex_value(rx_char);
          nxt.low_nibble_next = 1'b1;
        end
      end

      // complete a byte, emit the one held before it
      if (do_finish) begin
        new_byte            = {cur.high_nibble, low_val};
        nxt.low_nibble_next = 1'b0;
        if (cur.held_valid) begin
          res.data_valid = 1'b1;
          res.data_byte  = cur.held_byte;
        end
        nxt.running_sum = cur.running_sum + new_byte;
        nxt.held_byte   = new_byte;
        nxt.held_valid  = 1'b1;
        if (cur.decoded_count != COUNT_MAX) begin
          nxt.decoded_count = cur.decoded_count + 7'd1;
        end
        if (nxt.decoded_count >= max_bytes) begin
          nxt.frame_failed = 1'b1;
          nxt.held_valid   = 1'b0;
        end
      end

      if (is_newline) begin
        ok            = !nxt.frame_failed && (nxt.running_sum == SUM_TARGET);
        res.frame_end = 1'b1;
        res.frame_ok  = ok;
        if (ok && nxt.decoded_count != 7'd0) begin
          res.frame_length = 5'(nxt.decoded_count - 7'd1);
        end
        nxt.in_frame = 1'b0;
      end
    end
  end

  assign has_result = res.data_valid || res.frame_end;

endmodule

// ===== design/hex_frame_receiver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_frame_receiver
// ascii hex frame decoder with 8-bit sum check
// ----------------------------------------------------------------------------
// Takes one character per cycle while in_tready is high and updates the frame
// state at the same edge; a word that yields a decoded byte or a frame end is
// held in a single output register. Input is taken every cycle while that
// register is empty or being read, so throughput is one character per clock.
// max_bytes resets to 32 and should be written only while the stream is idle.
module hex_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,  // max_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // rx_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // data_byte[7:0], frame_ok[8], frame_length[13:9], zero
  output logic        out_tuser,    // data_valid
  output logic        out_tlast     // frame_end
);
  import hfr_pkg::*;

  logic [6:0]    max_bytes_r;
  frame_state_t  state_r;
  frame_state_t  state_nxt;
  frame_result_t res_nxt;
  frame_result_t res_r;
  logic          has_result;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          in_acc;

  hfr_step u_step (
    .cur        (state_r),
    .rx_char    (in_tdata),
    .max_bytes  (max_bytes_r),
    .nxt        (state_nxt),
    .res        (res_nxt),
    .has_result (has_result)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign out_valid_nxt = in_acc ? has_result : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_bytes_r <= cfg_wr_data;
      end
      if (in_acc) begin
        state_r <= state_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && has_result) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.frame_length, res_r.frame_ok, res_r.data_byte};
  assign out_tuser  = res_r.data_valid;
  assign out_tlast  = res_r.frame_end;

endmodule
